@@ hw/rtl/tss_pkg.sv @@
// tss_pkg: shared types and constants for the three-stack block
// request codes, status codes and the control bundle from tss_ctrl to the top level
// no dependencies
`default_nettype none

package tss_pkg;

	localparam int NUM_STACKS = 3;
	localparam int SEL_W      = 2;
	localparam int OP_W       = 2;
	localparam int WORD_W     = 32;

	localparam logic signed [WORD_W-1:0] MOST_NEG = {1'b1, {(WORD_W-1){1'b0}}};

	typedef enum logic [OP_W-1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_PEEK = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	// per-request decision from the control unit
	typedef struct packed {
		logic    wr_en;
		logic    rd_en;
		logic    pop;
		status_t status;
	} ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/tss_if.sv @@
// tss_req_if and tss_rsp_if: valid/ready channels for requests and results
// depends on tss_pkg for field widths
`default_nettype none

interface tss_req_if;
	import tss_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          opcode;
	logic [SEL_W-1:0]         stack_sel;
	logic signed [WORD_W-1:0] push_value;

	modport source (output valid, opcode, stack_sel, push_value, input ready);
	modport sink   (input valid, opcode, stack_sel, push_value, output ready);
endinterface

interface tss_rsp_if;
	import tss_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] read_value;
	logic [1:0]               status;

	modport source (output valid, read_value, status, input ready);
	modport sink   (input valid, read_value, status, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tss_mem.sv @@
// tss_mem: single-port word store with registered read data
// depends on tss_pkg for the word width
`default_nettype none

module tss_mem #(
	parameter int WORDS = 96,
	parameter int AW    = 7
) (
	input  wire logic                             clk,
	input  wire logic                             wr_en,
	input  wire logic                             rd_en,
	input  wire logic [AW-1:0]                    addr,
	input  wire logic signed [tss_pkg::WORD_W-1:0] wdata,
	output logic signed [tss_pkg::WORD_W-1:0]      rdata
);
	import tss_pkg::*;

	logic signed [WORD_W-1:0] mem_q [WORDS];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[addr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/tss_ctrl.sv @@
// tss_ctrl: fill counts of the three stacks, request decode and store addressing
// depends on tss_pkg
`default_nettype none

module tss_ctrl #(
	parameter int STACK_DEPTH = 32,
	parameter int AW          = 7,
	parameter int CW          = 6
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         accept,
	input  wire logic [tss_pkg::OP_W-1:0]     opcode,
	input  wire logic [tss_pkg::SEL_W-1:0]    stack_sel,
	output tss_pkg::ctrl_t                    ctrl,
	output logic [AW-1:0]                     addr
);
	import tss_pkg::*;

	localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
	localparam logic [AW-1:0] BASE_B  = AW'(STACK_DEPTH);
	localparam logic [AW-1:0] BASE_C  = AW'(2 * STACK_DEPTH);

	logic [CW-1:0] cnt_q [NUM_STACKS];
	logic [CW-1:0] cur;
	logic [AW-1:0] base;
	logic          sel_ok;

	// selected stack's count and region base
	always_comb begin
		sel_ok = 1'b1;
		cur    = cnt_q[0];
		base   = '0;
		case (stack_sel)
			2'd0: begin
				cur  = cnt_q[0];
				base = '0;
			end
			2'd1: begin
				cur  = cnt_q[1];
				base = BASE_B;
			end
			2'd2: begin
				cur  = cnt_q[2];
				base = BASE_C;
			end
			default: begin
				sel_ok = 1'b0;
			end
		endcase
	end

	// request decode
	always_comb begin
		ctrl = '{wr_en: 1'b0, rd_en: 1'b0, pop: 1'b0, status: ST_OK};
		if (!sel_ok) begin
			ctrl.status = ST_INVALID;
		end else begin
			case (op_t'(opcode))
				OP_PUSH: begin
					if (cur == DEPTH_C) ctrl.status = ST_FULL;
					else                ctrl.wr_en  = 1'b1;
				end
				OP_POP, OP_PEEK: begin
					if (cur == '0) begin
						ctrl.status = ST_EMPTY;
					end else begin
						ctrl.rd_en = 1'b1;
						ctrl.pop   = (op_t'(opcode) == OP_POP);
					end
				end
				default: begin
					ctrl.status = ST_INVALID;
				end
			endcase
		end
	end

	// push writes at the count, reads take the entry below it
	assign addr = base + AW'(cur) - AW'(ctrl.rd_en);

	// fill count update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STACKS; i++) cnt_q[i] <= '0;
		end else if (accept) begin
			for (int i = 0; i < NUM_STACKS; i++) begin
				if (stack_sel == SEL_W'(i)) begin
					if (ctrl.wr_en)    cnt_q[i] <= cnt_q[i] + CW'(1);
					else if (ctrl.pop) cnt_q[i] <= cnt_q[i] - CW'(1);
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[0] <= DEPTH_C && cnt_q[1] <= DEPTH_C && cnt_q[2] <= DEPTH_C)
		else $error("fill count above stack depth");

	a_wr_rd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.wr_en && ctrl.rd_en))
		else $error("store written and read by one request");

	a_access_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.wr_en || ctrl.rd_en) |-> ctrl.status == ST_OK)
		else $error("store access on a refused request");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ctrl.wr_en && stack_sel == 2'd0 |=> cnt_q[0] == $past(cnt_q[0]) + CW'(1))
		else $error("push did not raise the fill count");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/three_stacks_shared_array_top.sv @@
// three_stacks_shared_array_top: three stacks sharing one word store
// instantiates tss_ctrl and tss_mem; depends on tss_pkg, tss_req_if and tss_rsp_if
//
// Usage:
//   req channel carries opcode (push, pop, peek), stack_sel (0 to 2) and push_value.
//   rsp channel returns one result per request: read_value and status
//   (ok, full on push, empty on pop/peek, invalid for stack 3 or opcode 3).
//   read_value holds the top word for a successful pop or peek, else the most
//   negative 32-bit value.
// Timing:
//   a request taken by the handshake passes through the read stage, which
//   waits for store data, and then the output register, which holds its result.
//   One request per cycle is sustained while rsp.ready is high; each makes one
//   access to the single-port store, which sets that figure. Fill counts update
//   at the accept edge, so back-to-back requests on the same stack see each other.
// Reset:
//   arst_n clears all fill counts and empties the pipeline; the store keeps
//   old words, which are never read before a push writes them.
// Stall:
//   a result waits in the output register while rsp.ready is low; one more
//   request can sit in the read stage, then req.ready drops.
`default_nettype none

module three_stacks_shared_array_top #(
	parameter int STACK_DEPTH = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tss_req_if.sink     req,
	tss_rsp_if.source   rsp
);
	import tss_pkg::*;

	localparam int WORDS = NUM_STACKS * STACK_DEPTH;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CW    = $clog2(STACK_DEPTH + 1);

	ctrl_t                    ctrl;
	logic [AW-1:0]            addr;
	logic signed [WORD_W-1:0] rdata;
	logic                     accept;
	logic                     adv;

	logic                     valid_s1;
	logic                     rd_s1;
	status_t                  status_s1;

	logic                     out_valid_q;
	logic signed [WORD_W-1:0] out_value_q;
	status_t                  out_status_q;

	// handshake
	assign accept    = req.valid && req.ready;
	assign adv       = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	tss_ctrl #(
		.STACK_DEPTH(STACK_DEPTH),
		.AW(AW),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.opcode(req.opcode),
		.stack_sel(req.stack_sel),
		.ctrl(ctrl),
		.addr(addr)
	);

	tss_mem #(
		.WORDS(WORDS),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.wr_en(accept && ctrl.wr_en),
		.rd_en(accept && ctrl.rd_en),
		.addr(addr),
		.wdata(req.push_value),
		.rdata(rdata)
	);

	// read stage: waits for store data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1     <= ctrl.rd_en;
			status_s1 <= ctrl.status;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_value_q  <= rd_s1 ? rdata : MOST_NEG;
			out_status_q <= status_s1;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_value = out_value_q;
	assign rsp.status     = out_status_q;

`ifndef NO_ASSERTIONS
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(status_s1) && $stable(rd_s1)
			&& (!rd_s1 || $stable(rdata)))
		else $error("read stage lost a request while stalled");

	a_accept_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request missing from read stage");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp.ready |-> !adv)
		else $error("stalled result overwritten");
`endif

endmodule

`default_nettype wire
